// ===== rtl/uart_trx_pkg.sv =====
// ============================================================================
// UART transceiver package
// Shared request types, register indexes, operation codes and timing constants.
// ============================================================================
package uart_trx_pkg;

    // Frame layout
    localparam int DATA_BITS = 8;
    localparam int BITPOS_W  = $clog2(DATA_BITS + 2);
    localparam int TICK_W    = 17;
    localparam int STEP_W    = 17;

    // Configuration registers
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_TICKS = CFG_INDEX_W'(1);
    localparam logic [15:0] BIT_TICKS_RESET  = 16'd998;
    localparam logic [15:0] POLL_TICKS_RESET = 16'd30;

    // Operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_RECV = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  tx_byte;
        logic        rx_line;
        logic [15:0] rx_step_limit;
    } in_item_t;

    typedef struct packed {
        logic        tx_line;
        logic        tx_done;
        logic        rx_done;
        logic [7:0]  rx_data;
        logic        rx_timed_out;
        logic        busy_res;
    } out_item_t;

endpackage

// ===== rtl/uart_byte_tx_rx_with_timeout_core.sv =====
// ============================================================================
// UART byte transmitter / receiver with receive timeout
// 8N1 serial transmit and polled receive, one request per clock tick.
// ============================================================================
// Each accepted request is one tick of the bit timing base and produces
// exactly one result request. A request can be taken every cycle: the state
// update and the result are computed by a single layer of logic between the
// state registers and the result register, so throughput is one request per
// cycle as long as m_ready is high; s_ready drops only while a result sits in
// the result register and m_ready is low. Operation SEND (while idle) starts
// an 8N1 frame on tx_line: start bit, data LSB first, stop bit, each
// bit_ticks ticks long, with tx_done pulsing on the tick the stop bit ends.
// Operation RECV (while idle) starts a reception: rx_line is polled every
// poll_ticks ticks until it reads low, then sampled 1.5 bit times later and
// every bit time after that; the byte is reported with rx_done one bit time
// after the last sample (the stop bit is not checked). Every poll or sample
// is a step; once more than rx_step_limit+1 steps pass without finishing,
// rx_done and rx_timed_out are reported with rx_data 0 and the receiver goes
// idle. Operations issued while busy_res is high are ignored. Write the
// timing registers (index 0 bit_ticks, index 1 poll_ticks) only while idle;
// zero waits are treated as one tick.
// ============================================================================
module uart_byte_tx_rx_with_timeout_core
    import uart_trx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam logic [BITPOS_W-1:0] LAST_DATA_POS = BITPOS_W'(DATA_BITS);
    localparam logic [BITPOS_W-1:0] STOP_POS      = BITPOS_W'(DATA_BITS + 1);
    localparam logic [BITPOS_W-1:0] FIRST_POS     = BITPOS_W'(1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [15:0]          bit_ticks_reg;
    logic [15:0]          poll_ticks_reg;
    mode_t                mode_reg,         mode_next;
    logic [BITPOS_W-1:0]  bit_position_reg, bit_position_next;
    logic [TICK_W-1:0]    tick_count_reg,   tick_count_next;
    logic [7:0]           shift_byte_reg,   shift_byte_next;
    logic [STEP_W-1:0]    step_count_reg,   step_count_next;
    logic [15:0]          step_limit_reg,   step_limit_next;
    logic                 line_out_reg,     line_out_next;
    logic                 m_valid_reg;
    out_item_t            m_data_reg,       m_data_next;

    logic in_accept;

    // The result register frees up when empty or when drained this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ------------------------------------------------------------------
    // Receive step: one poll or one sample
    // ------------------------------------------------------------------
    logic                 rx_start;
    logic                 rx_step;
    logic [BITPOS_W-1:0]  step_bp_in;
    logic [7:0]           step_shift_in;
    logic [STEP_W-1:0]    step_count_in;
    logic [15:0]          step_limit_in;
    logic                 step_byte_done;
    logic                 step_timeout;
    logic [BITPOS_W-1:0]  step_bp;
    logic [TICK_W-1:0]    step_tick;
    logic [7:0]           step_shift;
    logic [BITPOS_W-1:0]  sample_idx;
    logic [TICK_W-1:0]    start_wait;

    assign rx_start = (mode_reg == MODE_IDLE) && (s_data.operation == OP_RECV);
    assign rx_step  = rx_start ||
                      ((mode_reg == MODE_RX) && (tick_count_reg <= TICK_W'(1)));

    // A fresh reception starts from cleared state and the request's limit.
    assign step_bp_in    = rx_start ? '0 : bit_position_reg;
    assign step_shift_in = rx_start ? '0 : shift_byte_reg;
    assign step_count_in = rx_start ? '0 : step_count_reg;
    assign step_limit_in = rx_start ? s_data.rx_step_limit : step_limit_reg;

    assign sample_idx = step_bp_in - FIRST_POS;
    // 1.5 bit times to land mid first data bit
    assign start_wait = {1'b0, bit_ticks_reg} + {2'b00, bit_ticks_reg[15:1]};

    always_comb begin
        step_byte_done = step_bp_in > LAST_DATA_POS;
        step_bp        = step_bp_in;
        step_shift     = step_shift_in;
        step_tick      = '0;
        if (step_bp_in == '0) begin
            if (!s_data.rx_line) begin
                step_bp   = FIRST_POS;
                step_tick = (start_wait == '0) ? TICK_W'(1) : start_wait;
            end else begin
                step_tick = (poll_ticks_reg == '0) ? TICK_W'(1) :
                            TICK_W'(poll_ticks_reg);
            end
        end else if (!step_byte_done) begin
            if (sample_idx < BITPOS_W'(8)) begin
                step_shift[sample_idx[2:0]] = s_data.rx_line;
            end
            step_bp   = step_bp_in + FIRST_POS;
            step_tick = (bit_ticks_reg == '0) ? TICK_W'(1) : TICK_W'(bit_ticks_reg);
        end
        step_timeout = !step_byte_done && (step_count_in > STEP_W'(step_limit_in));
    end

    // ------------------------------------------------------------------
    // Transmit bit timing
    // ------------------------------------------------------------------
    logic                tx_advance;
    logic [BITPOS_W-1:0] tx_bp;
    logic [BITPOS_W-1:0] tx_idx;
    logic                tx_finish;

    assign tx_advance = tick_count_reg >= TICK_W'(bit_ticks_reg);
    assign tx_bp      = bit_position_reg + FIRST_POS;
    assign tx_idx     = tx_bp - FIRST_POS;
    assign tx_finish  = (mode_reg == MODE_TX) && tx_advance && (tx_bp > STOP_POS);

    // ------------------------------------------------------------------
    // Next mode
    // ------------------------------------------------------------------
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (s_data.operation == OP_SEND) begin
                    mode_next = MODE_TX;
                end else if (rx_start) begin
                    mode_next = (step_byte_done || step_timeout) ? MODE_IDLE : MODE_RX;
                end
            end
            MODE_TX: begin
                if (tx_finish) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_RX: begin
                if (rx_step && (step_byte_done || step_timeout)) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------
    always_comb begin
        bit_position_next = bit_position_reg;
        tick_count_next   = tick_count_reg;
        shift_byte_next   = shift_byte_reg;
        step_count_next   = step_count_reg;
        step_limit_next   = step_limit_reg;
        line_out_next     = line_out_reg;
        m_data_next       = '0;

        if (mode_reg == MODE_IDLE && s_data.operation == OP_SEND) begin
            // the starting tick is the first tick of the start bit
            shift_byte_next   = s_data.tx_byte;
            bit_position_next = '0;
            tick_count_next   = TICK_W'(1);
            line_out_next     = 1'b0;
        end else if (mode_reg == MODE_TX) begin
            if (!tx_advance) begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end else if (tx_bp > STOP_POS) begin
                line_out_next        = 1'b1;
                bit_position_next    = '0;
                tick_count_next      = '0;
                m_data_next.tx_done  = 1'b1;
            end else begin
                bit_position_next = tx_bp;
                tick_count_next   = TICK_W'(1);
                if (tx_bp <= LAST_DATA_POS) begin
                    line_out_next = (tx_idx < BITPOS_W'(8)) ?
                                    shift_byte_reg[tx_idx[2:0]] : 1'b0;
                end else begin
                    line_out_next = 1'b1;
                end
            end
        end else if (rx_step) begin
            step_limit_next = step_limit_in;
            shift_byte_next = step_shift;
            if (step_byte_done) begin
                m_data_next.rx_done = 1'b1;
                m_data_next.rx_data = step_shift_in;
                bit_position_next   = '0;
                tick_count_next     = '0;
                step_count_next     = step_count_in;
            end else if (step_timeout) begin
                m_data_next.rx_done      = 1'b1;
                m_data_next.rx_timed_out = 1'b1;
                bit_position_next        = '0;
                tick_count_next          = '0;
                step_count_next          = step_count_in;
            end else begin
                bit_position_next = step_bp;
                tick_count_next   = step_tick;
                step_count_next   = step_count_in + STEP_W'(1);
            end
        end else if (mode_reg == MODE_RX) begin
            tick_count_next = tick_count_reg - TICK_W'(1);
        end

        m_data_next.tx_line  = line_out_next;
        m_data_next.busy_res = (mode_next != MODE_IDLE);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg  <= BIT_TICKS_RESET;
            poll_ticks_reg <= POLL_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_BIT_TICKS) begin
                bit_ticks_reg <= cfg_data;
            end else if (cfg_index == CFG_POLL_TICKS) begin
                poll_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            bit_position_reg <= '0;
            tick_count_reg   <= '0;
            shift_byte_reg   <= '0;
            step_count_reg   <= '0;
            step_limit_reg   <= '0;
            line_out_reg     <= 1'b1;
        end else if (in_accept) begin
            mode_reg         <= mode_next;
            bit_position_reg <= bit_position_next;
            tick_count_reg   <= tick_count_next;
            shift_byte_reg   <= shift_byte_next;
            step_count_reg   <= step_count_next;
            step_limit_reg   <= step_limit_next;
            line_out_reg     <= line_out_next;
        end
    end

    // Hold the result until taken; load a new one on every accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (bit_position_reg == '0 && tick_count_reg == '0))
        else $error("idle with live bit position or tick count");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_RX) |-> (step_count_reg <= STEP_W'(step_limit_reg) + STEP_W'(1)))
        else $error("receive step count ran past limit");

    a_timeout_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.rx_timed_out) |->
            (m_data_reg.rx_done && m_data_reg.rx_data == 8'd0 && !m_data_reg.busy_res))
        else $error("timeout result malformed");

    a_done_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.tx_done && m_data_reg.rx_done))
        else $error("transmit and receive done together");

    a_tx_done_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && tx_finish) |=> (mode_reg == MODE_IDLE && line_out_reg))
        else $error("transmit end left line low or busy");

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// UART transceiver core testbench
// Drives clock-tick requests into the transceiver core and checks every
// result against a cycle-exact software copy of the transmit and receive
// state machines, across several bit and poll timings and step limits.
// ============================================================================
module testbench
    import uart_trx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Unused operation code: the core must ignore it.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 150;
    localparam int         DRAIN_LIMIT = 2000;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data  = '0;

    uart_byte_tx_rx_with_timeout_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Line state of the transceiver, advanced once per accepted tick request
    // ------------------------------------------------------------------------
    mode_t               u_mode;
    logic [BITPOS_W-1:0] u_bitpos;
    logic [TICK_W-1:0]   u_ticks;
    logic [7:0]          u_shift;
    logic [STEP_W-1:0]   u_steps;
    logic [15:0]         u_limit;
    logic                u_line;
    logic [15:0]         u_bit_ticks;
    logic [15:0]         u_poll_ticks;

    out_item_t pending_tick_results[$];

    // Run bookkeeping
    int  ticks_accepted;
    int  results_checked;
    int  mismatch_count;
    int  stray_results;
    int  bytes_sent;
    int  bytes_received;
    int  rx_timeouts;
    int  result_stalls;
    int  request_stalls;
    bit  sender_idling   = 1'b1;
    bit  receiver_idling = 1'b1;
    int  hold_requests   = 0;
    int  hold_served     = 0;
    int  hold_left       = 0;

    // A wait of zero ticks still lasts one tick.
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // Drop the receiver back to idle.
    function automatic void rx_to_idle();
        u_mode   = MODE_IDLE;
        u_bitpos = '0;
        u_ticks  = '0;
    endfunction

    // One receive step: a poll while hunting, a data sample, or the end of the byte.
    function automatic void rx_take_step(input logic line, inout out_item_t res);
        logic [17:0] three_halves;
        if (u_bitpos == '0) begin
            if (!line) begin
                three_halves = ({2'b00, u_bit_ticks} * 18'd3) / 18'd2;
                u_bitpos     = BITPOS_W'(1);
                u_ticks      = at_least_one(TICK_W'(three_halves));
            end else begin
                u_ticks = at_least_one({1'b0, u_poll_ticks});
            end
        end else if (int'(u_bitpos) <= DATA_BITS) begin
            if (int'(u_bitpos) <= 8)
                u_shift[u_bitpos - 1'b1] = line;
            u_bitpos = u_bitpos + 1'b1;
            u_ticks  = at_least_one({1'b0, u_bit_ticks});
        end else begin
            res.rx_done = 1'b1;
            res.rx_data = u_shift;
            rx_to_idle();
            return;
        end
        // A step that does not end the byte times out once the earlier
        // step count has passed the limit.
        if (u_steps > {1'b0, u_limit}) begin
            res.rx_done      = 1'b1;
            res.rx_data      = 8'h00;
            res.rx_timed_out = 1'b1;
            rx_to_idle();
            return;
        end
        u_steps = u_steps + 1'b1;
    endfunction

    // Advance the line state by one tick and return the result it produces.
    function automatic out_item_t uart_tick_result(input in_item_t it);
        out_item_t res;
        res = '0;
        case (u_mode)
            MODE_IDLE: begin
                if (it.operation == OP_SEND) begin
                    u_mode   = MODE_TX;
                    u_shift  = it.tx_byte;
                    u_bitpos = '0;
                    u_ticks  = TICK_W'(1);
                    u_line   = 1'b0;
                end else if (it.operation == OP_RECV) begin
                    u_mode   = MODE_RX;
                    u_shift  = 8'h00;
                    u_bitpos = '0;
                    u_steps  = '0;
                    u_limit  = it.rx_step_limit;
                    rx_take_step(it.rx_line, res);
                end
            end
            MODE_TX: begin
                if (u_ticks < {1'b0, u_bit_ticks}) begin
                    u_ticks = u_ticks + 1'b1;
                end else begin
                    u_bitpos = u_bitpos + 1'b1;
                    u_ticks  = TICK_W'(1);
                    if (int'(u_bitpos) <= DATA_BITS) begin
                        // Bits past the byte go out low.
                        u_line = (int'(u_bitpos) <= 8) ? u_shift[u_bitpos - 1'b1] : 1'b0;
                    end else if (int'(u_bitpos) == DATA_BITS + 1) begin
                        u_line = 1'b1;
                    end else begin
                        u_line      = 1'b1;
                        u_bitpos    = '0;
                        u_ticks     = '0;
                        u_mode      = MODE_IDLE;
                        res.tx_done = 1'b1;
                    end
                end
            end
            MODE_RX: begin
                if (u_ticks <= TICK_W'(1))
                    rx_take_step(it.rx_line, res);
                else
                    u_ticks = u_ticks - 1'b1;
            end
            default: u_mode = MODE_IDLE;
        endcase
        res.tx_line  = u_line;
        res.busy_res = (u_mode != MODE_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one tick request; hold valid and payload until it is taken.
    task automatic offer_tick(input in_item_t it);
        @(negedge aclk);
        while (sender_idling && $urandom_range(99, 0) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_tick_results.push_back(uart_tick_result(it));
        ticks_accepted++;
    endtask

    task automatic offer_op(input logic [1:0] op, input logic [7:0] value,
                            input logic line, input logic [15:0] limit);
        in_item_t it;
        it.operation     = op;
        it.tx_byte       = value;
        it.rx_line       = line;
        it.rx_step_limit = limit;
        offer_tick(it);
    endtask

    // Plain tick; while a transfer runs, throw in random operations that
    // the core must ignore.
    task automatic tick_with(input logic line);
        logic [1:0] op;
        op = (u_mode == MODE_IDLE) ? OP_TICK : 2'($urandom_range(3, 0));
        offer_op(op, 8'($urandom), line, 16'($urandom));
    endtask

    // Tick until the transfer in flight ends. A low line makes a hunting
    // receiver pick up a start bit, so this is always bounded.
    task automatic settle();
        while (u_mode != MODE_IDLE)
            tick_with(1'b0);
    endtask

    // Drop valid and wait for every outstanding result, with a cap.
    task automatic drain_results();
        int waited;
        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (pending_tick_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (3) @(posedge aclk);
    endtask

    // Write a timing register while the core sits idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        settle();
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (index == CFG_BIT_TICKS)
            u_bit_ticks = value;
        else if (index == CFG_POLL_TICKS)
            u_poll_ticks = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] bit_len, input logic [15:0] poll_len);
        write_reg(CFG_BIT_TICKS, bit_len);
        write_reg(CFG_POLL_TICKS, poll_len);
    endtask

    // Send one byte and tick until the stop bit ends.
    task automatic send_byte(input logic [7:0] value);
        settle();
        offer_op(OP_SEND, value, 1'($urandom), 16'($urandom));
        while (u_mode != MODE_IDLE)
            tick_with(1'($urandom));
    endtask

    // Start a reception and play a clean 8N1 frame on rx_line after lead
    // idle-high ticks.
    task automatic receive_frame(input logic [7:0] value, input int lead,
                                 input logic [15:0] limit);
        int   bit_len;
        int   n;
        int   slot;
        logic line;
        settle();
        bit_len = (u_bit_ticks == 16'd0) ? 1 : int'(u_bit_ticks);
        for (n = 0; n < lead + 10 * bit_len; n++) begin
            slot = (n - lead) / bit_len;
            if (n < lead)
                line = 1'b1;
            else if (slot == 0)
                line = 1'b0;
            else if (slot <= 8)
                line = value[slot - 1];
            else
                line = 1'b1;
            if (n == 0)
                offer_op(OP_RECV, 8'($urandom), line, limit);
            else
                tick_with(line);
        end
        settle();
    endtask

    // Start a reception on a noisy line.
    task automatic receive_noise(input int len, input logic [15:0] limit);
        settle();
        offer_op(OP_RECV, 8'($urandom), 1'($urandom), limit);
        repeat (len)
            tick_with(1'($urandom));
        settle();
    endtask

    // Idle ticks with unused or tick-only operations and random fields.
    task automatic idle_noise(input int len);
        settle();
        repeat (len)
            offer_op($urandom_range(1, 0) ? OP_TICK : OP_UNUSED, 8'($urandom),
                     1'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Drop m_ready at random, and for a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (receiver_idling && $urandom_range(99, 0) < 36) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] result %0d %s mismatch: expected %h, got %h",
                     $realtime, results_checked, field, want, got);
    endtask

    // Compare each taken result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn) begin
            if (m_valid && !m_ready)
                result_stalls++;
            if (s_valid && !s_ready)
                request_stalls++;
            if (m_valid && m_ready) begin
                if (pending_tick_results.size() == 0) begin
                    stray_results++;
                    if (stray_results <= 10)
                        $display("[%0t] result with no request outstanding: %h",
                                 $realtime, m_data);
                end else begin
                    want = pending_tick_results.pop_front();
                    if (m_data.tx_line !== want.tx_line)
                        note_mismatch("tx_line", want.tx_line, m_data.tx_line);
                    if (m_data.tx_done !== want.tx_done)
                        note_mismatch("tx_done", want.tx_done, m_data.tx_done);
                    if (m_data.rx_done !== want.rx_done)
                        note_mismatch("rx_done", want.rx_done, m_data.rx_done);
                    if (m_data.rx_data !== want.rx_data)
                        note_mismatch("rx_data", want.rx_data, m_data.rx_data);
                    if (m_data.rx_timed_out !== want.rx_timed_out)
                        note_mismatch("rx_timed_out", want.rx_timed_out,
                                      m_data.rx_timed_out);
                    if (m_data.busy_res !== want.busy_res)
                        note_mismatch("busy_res", want.busy_res, m_data.busy_res);
                    if (want.tx_done)
                        bytes_sent++;
                    if (want.rx_done && want.rx_timed_out)
                        rx_timeouts++;
                    else if (want.rx_done)
                        bytes_received++;
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset timing: unused and tick-only operations while idle, and a poll
    // timeout at limit zero at the reset poll interval.
    task automatic test_reset_defaults();
        offer_op(OP_TICK, 8'hFF, 1'b0, 16'hFFFF);
        offer_op(OP_UNUSED, 8'h00, 1'b1, 16'h0000);
        offer_op(OP_UNUSED, 8'hFF, 1'b0, 16'hFFFF);
        offer_op(OP_RECV, 8'h00, 1'b1, 16'h0000);
        while (u_mode != MODE_IDLE)
            tick_with(1'b1);
    endtask

    // Short bit time: extreme bytes each way, and limits on both sides of
    // the step count a clean frame needs.
    task automatic test_frame_extremes();
        set_timing(16'd4, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        receive_frame(8'h00, 3, 16'hFFFF);
        receive_frame(8'hFF, 5, 16'hFFFF);
        receive_frame(8'h5A, 0, 16'd8);
        receive_frame(8'h5A, 0, 16'd7);
        receive_frame(8'h3C, 0, 16'd0);
        receive_frame(8'hC3, 4, 16'd3);
        receive_noise(20, 16'd5);
    endtask

    // Zero in both timing registers: every wait lasts one tick.
    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0);
        send_byte(8'h3C);
        receive_frame(8'hC3, 2, 16'hFFFF);
        receive_frame(8'h96, 0, 16'd2);
        receive_noise(12, 16'd30);
    endtask

    // Widest step limits on clean frames and a noisy line, with no idling
    // on either side for the whole stretch.
    task automatic test_wide_limits();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        set_timing(16'd4, 16'd1);
        receive_frame(8'h69, 1, 16'hFFFF);
        send_byte(8'h96);
        receive_noise(30, 16'hFFFF);
        receive_frame(8'h01, 0, 16'hFFFE);
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
    endtask

    // Hold the result side off while requests keep coming, so the core fills
    // and drops s_ready.
    task automatic test_backpressure();
        set_timing(16'd4, 16'd2);
        hold_requests++;
        send_byte(8'($urandom));
        hold_requests++;
        receive_frame(8'($urandom), 2, 16'hFFFF);
    endtask

    // Random mix per timing setting: mostly clean frames both ways, some
    // tight limits, noisy lines and idle ticks.
    task automatic test_random_traffic();
        int          phase;
        int          first;
        int          pick;
        logic [15:0] bit_len;
        logic [15:0] poll_len;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin bit_len = 16'd4; poll_len = 16'd1;  end
                1:       begin bit_len = 16'd5; poll_len = 16'd3;  end
                2:       begin bit_len = 16'd8; poll_len = 16'd8;  end
                default: begin bit_len = 16'd6; poll_len = 16'd11; end
            endcase
            set_timing(bit_len, poll_len);
            first = ticks_accepted;
            while (ticks_accepted - first < 200) begin
                pick = $urandom_range(99, 0);
                if (pick < 40)
                    receive_frame(8'($urandom), $urandom_range(2 * poll_len, 0),
                                  ($urandom_range(9, 0) < 7) ?
                                      16'($urandom_range(65535, 10)) :
                                      16'($urandom_range(12, 0)));
                else if (pick < 70)
                    send_byte(8'($urandom));
                else if (pick < 85)
                    receive_noise($urandom_range(40, 5), 16'($urandom_range(20, 0)));
                else
                    idle_noise($urandom_range(10, 1));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        u_mode       = MODE_IDLE;
        u_bitpos     = '0;
        u_ticks      = '0;
        u_shift      = 8'h00;
        u_steps      = '0;
        u_limit      = 16'h0000;
        u_line       = 1'b1;
        u_bit_ticks  = BIT_TICKS_RESET;
        u_poll_ticks = POLL_TICKS_RESET;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_frame_extremes();
        test_zero_timing();
        test_wide_limits();
        test_backpressure();
        test_random_traffic();

        settle();
        drain_results();
        if (pending_tick_results.size() != 0)
            $display("%0d expected results never arrived", pending_tick_results.size());

        $display("Run covered %0d ticks: %0d bytes sent, %0d bytes received, %0d rx timeouts",
                 ticks_accepted, bytes_sent, bytes_received, rx_timeouts);
        $display("Bit times 0 to 8, polls 0 to 30, limits 0 to 65535; %0d/%0d stalls",
                 result_stalls, request_stalls);
        if (mismatch_count == 0 && stray_results == 0 && pending_tick_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== uart_byte_tx_rx_with_timeout_core.f =====
rtl/uart_trx_pkg.sv
rtl/uart_byte_tx_rx_with_timeout_core.sv
dv/testbench.sv
